### design/mrs_pkg.sv
// Shared types and constants for the RTU slave frame engine.
package mrs_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_FUNC  = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd2;
    localparam logic [2:0] ST_BAD_VALUE = 3'd3;
    localparam logic [2:0] ST_CRC_ERR   = 3'd4;

    localparam logic [2:0] CFG_ADDR  = 3'd0;
    localparam logic [2:0] CFG_SHORT = 3'd1;
    localparam logic [2:0] CFG_LONG  = 3'd2;
    localparam logic [2:0] CFG_COILS = 3'd3;
    localparam logic [2:0] CFG_INPS  = 3'd4;

    localparam logic [7:0] FC_READ_COILS  = 8'd1;
    localparam logic [7:0] FC_READ_INPUTS = 8'd2;
    localparam logic [7:0] FC_WRITE_ONE   = 8'd5;
    localparam logic [7:0] FC_WRITE_MANY  = 8'd15;

    // One closed frame handed from the receive side to the reply side.
    typedef struct packed {
        logic [7:0][7:0] hdr;
        logic [7:0]      pins;
        logic            crc_bad;
    } t_frame;

    // One response byte with its side-band fields.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] coils;
        logic       last;
        logic [7:0] data;
    } t_txb;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

endpackage

### design/modbus_rtu_slave_frame_engine_core.sv
// Top level of the RTU slave frame engine.
// The engine takes one transaction per cycle from the input stream while tready is high:
// a received byte (tuser = 0) or one timer tick (tuser = 1). The receive side times line
// silence, collects a frame and runs its CRC, one byte per cycle while input flows. A
// closing tick that ends a frame with our address and over four bytes passes its header
// to the reply side in the next cycle. The reply side decides the request, updates the
// coils and emits the response at one byte per cycle while m_axis_tready is high (five to
// eight bytes, CRC low byte first), the first byte passing through the frame valid, reply
// and output registers when the reply side is free. A one-frame holding slot sits between
// the two sides: a frame that closes while an earlier reply is still draining waits there,
// and input is stalled only while that slot is occupied. Configuration writes are accepted
// in every cycle and should be made only while no frame or reply is in flight.
module modbus_rtu_slave_frame_engine_core #(
    parameter int MAX_FRAME = 255,
    parameter int PIN_BITS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte [7:0], input_pins [15:8]
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // tx_byte [7:0], coil_bits [15:8]
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser,   // reply_status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [7:0]  r_addr;
    logic [15:0] r_short, r_long;
    logic [3:0]  r_nc, r_ni;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= 8'd1; r_short <= 16'd16; r_long <= 16'd40;
            r_nc <= 4'd3; r_ni <= 4'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mrs_pkg::CFG_ADDR:  r_addr  <= i_cfg_data[7:0];
                mrs_pkg::CFG_SHORT: r_short <= i_cfg_data;
                mrs_pkg::CFG_LONG:  r_long  <= i_cfg_data;
                mrs_pkg::CFG_COILS: r_nc    <= i_cfg_data[3:0];
                mrs_pkg::CFG_INPS:  r_ni    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic            w_fv, w_busy;
    mrs_pkg::t_frame w_frame;
    mrs_pkg::t_txb   w_txb;

    // Hold input only while a closed frame already waits behind a draining reply.
    assign s_axis_tready = !w_busy;

    mrs_rx #(.MAX_FRAME(MAX_FRAME), .PIN_BITS(PIN_BITS)) u_rx (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(s_axis_tvalid && s_axis_tready),
        .i_kind(s_axis_tuser), .i_byte(s_axis_tdata[7:0]), .i_pins(s_axis_tdata[15:8]),
        .i_addr(r_addr), .i_gap_short(r_short), .i_gap_long(r_long),
        .o_frame_valid(w_fv), .o_frame(w_frame)
    );

    mrs_exec u_exec (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_frame_valid(w_fv), .i_frame(w_frame),
        .i_addr(r_addr), .i_coil_count(r_nc), .i_input_count(r_ni),
        .o_busy(w_busy), .o_valid(m_axis_tvalid), .o_txb(w_txb), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {w_txb.coils, w_txb.data};
    assign m_axis_tlast = w_txb.last;
    assign m_axis_tuser = w_txb.status;
endmodule

### design/mrs_rx.sv
// Receive side: bus timing, frame capture and CRC check.
module mrs_rx #(
    parameter int MAX_FRAME = 255,
    parameter int PIN_BITS  = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item,
    input  logic                i_kind,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_pins,
    input  logic [7:0]          i_addr,
    input  logic [15:0]         i_gap_short,
    input  logic [15:0]         i_gap_long,
    output logic                o_frame_valid,
    output mrs_pkg::t_frame     o_frame
);
    typedef enum logic [1:0] {PH_WAIT, PH_IDLE, PH_RX} t_phase;

    t_phase          r_phase;
    logic [15:0]     r_gap;
    logic [7:0]      r_cnt;
    logic [7:0][7:0] r_hdr;
    logic [15:0]     r_crc;

    logic [15:0] w_gap_inc;
    logic [7:0]  w_pins;
    logic        w_close;
    assign w_gap_inc = (r_gap == 16'hFFFF) ? r_gap : r_gap + 16'd1;
    assign w_close   = i_item && i_kind && (r_phase == PH_RX) && (w_gap_inc >= i_gap_short);

    always_comb begin
        w_pins = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (i < PIN_BITS) w_pins[i] = i_pins[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_gap   <= '0;
            r_cnt   <= '0;
            r_crc   <= 16'hFFFF;
        end else if (i_item) begin
            if (!i_kind) begin
                r_gap <= '0;
                if (r_phase == PH_IDLE) begin
                    r_phase  <= PH_RX;
                    r_hdr[0] <= i_byte;
                    r_cnt    <= 8'd1;
                    r_crc    <= mrs_pkg::crc_byte(16'hFFFF, i_byte);
                end else if (r_phase == PH_RX) begin
                    if (32'(r_cnt) < MAX_FRAME) begin
                        if (r_cnt < 8'd8) r_hdr[r_cnt[2:0]] <= i_byte;
                        r_crc <= mrs_pkg::crc_byte(r_crc, i_byte);
                        r_cnt <= r_cnt + 8'd1;
                    end else begin
                        r_phase <= PH_WAIT;
                        r_cnt   <= '0;
                        r_crc   <= 16'hFFFF;
                    end
                end
            end else if (r_phase != PH_IDLE) begin
                if (w_close) begin
                    r_phase <= PH_WAIT;
                    r_gap   <= '0;
                    r_cnt   <= '0;
                    r_crc   <= 16'hFFFF;
                end else if (r_phase == PH_WAIT && w_gap_inc >= i_gap_long) begin
                    r_phase <= PH_IDLE;
                    r_gap   <= '0;
                end else begin
                    r_gap <= w_gap_inc;
                end
            end
        end
    end

    // Frame closes; hand it over only if it can produce a reply.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_frame_valid <= 1'b0;
        else o_frame_valid <= w_close && (r_cnt > 8'd4) && (r_hdr[0] == i_addr);
    end

    // Header bytes past the received length read as zero.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 8; i++) begin
            o_frame.hdr[i] <= (8'(i) < r_cnt) ? r_hdr[i] : 8'h00;
        end
        o_frame.pins    <= w_pins;
        o_frame.crc_bad <= (r_crc != 16'h0000);
    end
endmodule

### design/mrs_exec.sv
// Reply side: request decode, coil update and response byte generation.
module mrs_exec (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_frame_valid,
    input  mrs_pkg::t_frame  i_frame,
    input  logic [7:0]       i_addr,
    input  logic [3:0]       i_coil_count,
    input  logic [3:0]       i_input_count,
    output logic             o_busy,
    output logic             o_valid,
    output mrs_pkg::t_txb    o_txb,
    input  logic             i_ready
);
    logic [7:0]      r_coils;
    logic [7:0][7:0] r_rep;
    logic [3:0]      r_len;
    logic [3:0]      r_idx;
    logic [2:0]      r_status;
    logic            r_act;
    logic [15:0]     r_crc;
    logic            r_pv;
    mrs_pkg::t_frame r_pend;

    mrs_pkg::t_frame w_cur;
    logic            w_start;
    logic [7:0]  w_fc;
    logic [15:0] w_a, w_q;
    logic [4:0]  w_nc, w_ni, w_lim;
    logic [2:0]  w_st;
    logic [7:0]  w_coils, w_mask, w_src;
    logic [7:0][7:0] w_rep;
    logic [3:0]  w_len;
    logic        w_rng;
    logic [16:0] w_end;

    // A frame that closes while a reply drains waits in the holding slot.
    assign w_cur   = r_pv ? r_pend : i_frame;
    assign w_start = (r_pv || i_frame_valid) && !r_act;

    always_comb begin
        w_fc = w_cur.hdr[1];
        w_a  = {w_cur.hdr[2], w_cur.hdr[3]};
        w_q  = {w_cur.hdr[4], w_cur.hdr[5]};
        w_nc = (i_coil_count > 4'd8) ? 5'd8 : {1'b0, i_coil_count};
        w_ni = (i_input_count > 4'd8) ? 5'd8 : {1'b0, i_input_count};
        w_lim = (w_fc == mrs_pkg::FC_READ_INPUTS) ? w_ni : w_nc;
        w_end = {1'b0, w_a} + {1'b0, w_q};
        w_rng = (w_q != 16'd0) && (w_end <= {12'd0, w_lim});
        w_mask = '0;
        for (int i = 0; i < 8; i++) begin
            if (16'(i) < w_q) w_mask[i] = 1'b1;
        end
        w_src = (w_fc == mrs_pkg::FC_READ_COILS) ? r_coils : w_cur.pins;
        w_coils = r_coils;
        w_st = mrs_pkg::ST_OK;
        w_rep = '0;
        w_rep[0] = i_addr;
        w_len = 4'd6;
        if (w_cur.crc_bad) begin
            w_st = mrs_pkg::ST_CRC_ERR;
        end else if (w_fc != mrs_pkg::FC_READ_COILS && w_fc != mrs_pkg::FC_READ_INPUTS
                     && w_fc != mrs_pkg::FC_WRITE_ONE && w_fc != mrs_pkg::FC_WRITE_MANY) begin
            w_st = mrs_pkg::ST_BAD_FUNC;
        end else if (w_a >= {11'd0, w_lim}) begin
            w_st = mrs_pkg::ST_BAD_ADDR;
        end else if (w_fc == mrs_pkg::FC_READ_COILS || w_fc == mrs_pkg::FC_READ_INPUTS) begin
            if (!w_rng) begin
                w_st = mrs_pkg::ST_BAD_VALUE;
            end else begin
                w_rep[1] = w_fc;
                w_rep[2] = 8'd1;
                w_rep[3] = (w_src >> w_a[2:0]) & w_mask;
                w_len = 4'd4;
            end
        end else if (w_fc == mrs_pkg::FC_WRITE_ONE) begin
            if (w_q == 16'hFF00) w_coils = r_coils | (8'd1 << w_a[2:0]);
            else if (w_q == 16'h0000) w_coils = r_coils & ~(8'd1 << w_a[2:0]);
            else w_st = mrs_pkg::ST_BAD_VALUE;
        end else begin
            if (!w_rng || w_cur.hdr[6] != 8'((w_q + 16'd7) >> 3)) begin
                w_st = mrs_pkg::ST_BAD_VALUE;
            end else begin
                w_coils = (r_coils & ~(w_mask << w_a[2:0]))
                        | ((w_cur.hdr[7] << w_a[2:0]) & (w_mask << w_a[2:0]));
            end
        end
        if (w_st == mrs_pkg::ST_OK && w_len == 4'd6) begin
            for (int i = 1; i < 6; i++) w_rep[i] = w_cur.hdr[i];
        end
        if (w_st != mrs_pkg::ST_OK) begin
            w_rep[1] = w_fc + 8'h80;
            w_rep[2] = {5'd0, w_st};
            w_len = 4'd3;
        end
    end

    // Reply bytes stream one a cycle while i_ready allows; the CRC runs alongside the data bytes.
    logic       w_take;
    logic [7:0] w_byte;
    assign w_take = o_valid && i_ready;
    always_comb begin
        if (r_idx < r_len) w_byte = r_rep[r_idx[2:0]];
        else if (r_idx == r_len) w_byte = r_crc[7:0];
        else w_byte = r_crc[15:8];
    end
    assign o_busy = r_pv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coils <= '0;
            r_act   <= 1'b0;
            r_pv    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_frame_valid && !w_start) begin
                r_pv   <= 1'b1;
                r_pend <= i_frame;
            end
            if (w_start) begin
                r_pv     <= 1'b0;
                r_coils  <= w_coils;
                r_rep    <= w_rep;
                r_len    <= w_len;
                r_status <= w_st;
                r_idx    <= '0;
                r_crc    <= 16'hFFFF;
                r_act    <= 1'b1;
                if (w_take) o_valid <= 1'b0;
            end else if (r_act && (!o_valid || w_take)) begin
                o_valid        <= 1'b1;
                o_txb.data     <= w_byte;
                o_txb.last     <= (r_idx == r_len + 4'd1);
                o_txb.coils    <= r_coils;
                o_txb.status   <= r_status;
                if (r_idx < r_len) r_crc <= mrs_pkg::crc_byte(r_crc, w_byte);
                r_idx <= r_idx + 4'd1;
                if (r_idx == r_len + 4'd1) r_act <= 1'b0;
            end else if (w_take) begin
                o_valid <= 1'b0;
            end
        end
    end
endmodule

### bench/tb.sv
// Self-checking bench for the RTU slave frame engine: request frames in, checked replies out.
module tb;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic [7:0] pins;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [7:0] coils;
        logic [2:0] status;
    } t_reply_byte;

    typedef enum logic [1:0] {
        LINE_WAIT_SILENCE,
        LINE_IDLE,
        LINE_RECEIVING
    } t_line_phase;

    localparam int MAX_FRAME_BYTES = 255;
    localparam int SETTLE_CYCLES   = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    modbus_rtu_slave_frame_engine_core DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the configuration and the line state.
    logic [7:0]  own_addr    = 8'd1;
    logic [15:0] short_gap   = 16'd16;
    logic [15:0] long_gap    = 16'd40;
    logic [3:0]  coil_num    = 4'd3;
    logic [3:0]  input_num   = 4'd3;
    t_line_phase line_phase  = LINE_WAIT_SILENCE;
    logic [15:0] silence_cnt = '0;
    logic [7:0]  frame_len   = '0;
    logic [7:0]  head_bytes [8];
    logic [15:0] frame_crc   = 16'hFFFF;
    logic [7:0]  coil_state  = '0;

    t_in_item    pending_items [$];
    t_reply_byte reply_fifo [$];
    int          error_count = 0;
    bit          idling_on   = 1'b1;

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        return r;
    endfunction

    function automatic logic [7:0] head_at(input int i);
        return (i < 8 && i < frame_len) ? head_bytes[i] : 8'h00;
    endfunction

    task automatic reset_frame();
        frame_len = '0;
        frame_crc = 16'hFFFF;
        for (int i = 0; i < 8; i++) head_bytes[i] = '0;
    endtask

    // Decide a closed frame and queue the reply bytes it produces.
    task automatic decode_frame(input logic [7:0] pins);
        logic [7:0]  rep [10];
        int          len;
        logic [2:0]  status;
        logic [7:0]  fc;
        int unsigned start, qty, ncoil, ninp, lim, src, mask;
        logic [15:0] crc;
        t_reply_byte rb;
        len = 0;
        status = mrs_pkg::ST_OK;
        fc = head_at(1);
        start = {head_at(2), head_at(3)};
        qty = {head_at(4), head_at(5)};
        ncoil = (coil_num > 8) ? 8 : coil_num;
        ninp = (input_num > 8) ? 8 : input_num;
        if (frame_len <= 4 || head_at(0) != own_addr) return;
        rep[0] = own_addr;
        lim = (fc == mrs_pkg::FC_READ_INPUTS) ? ninp : ncoil;
        if (frame_crc != 16'h0000) begin
            status = mrs_pkg::ST_CRC_ERR;
        end else if (fc != mrs_pkg::FC_READ_COILS && fc != mrs_pkg::FC_READ_INPUTS &&
                     fc != mrs_pkg::FC_WRITE_ONE && fc != mrs_pkg::FC_WRITE_MANY) begin
            status = mrs_pkg::ST_BAD_FUNC;
        end else if (start >= lim) begin
            status = mrs_pkg::ST_BAD_ADDR;
        end else if (fc == mrs_pkg::FC_READ_COILS || fc == mrs_pkg::FC_READ_INPUTS) begin
            if (qty < 1 || start + qty > lim) begin
                status = mrs_pkg::ST_BAD_VALUE;
            end else begin
                src = (fc == mrs_pkg::FC_READ_COILS) ? coil_state : pins;
                mask = (1 << qty) - 1;
                rep[1] = fc;
                rep[2] = 8'd1;
                rep[3] = 8'((src >> start) & mask);
                len = 4;
            end
        end else if (fc == mrs_pkg::FC_WRITE_ONE) begin
            if (qty == 16'hFF00) coil_state = coil_state | 8'(1 << start);
            else if (qty == 0) coil_state = coil_state & ~8'(1 << start);
            else status = mrs_pkg::ST_BAD_VALUE;
        end else begin
            if (qty < 1 || start + qty > ncoil || head_at(6) != 8'((qty + 7) / 8)) begin
                status = mrs_pkg::ST_BAD_VALUE;
            end else begin
                mask = ((1 << qty) - 1) << start;
                coil_state = 8'((coil_state & ~mask) | ((head_at(7) << start) & mask));
            end
        end
        if (status == mrs_pkg::ST_OK &&
            (fc == mrs_pkg::FC_WRITE_ONE || fc == mrs_pkg::FC_WRITE_MANY)) begin
            for (int i = 1; i < 6; i++) rep[i] = head_at(i);
            len = 6;
        end
        if (status != mrs_pkg::ST_OK) begin
            rep[1] = fc + 8'h80;
            rep[2] = 8'(status);
            len = 3;
        end
        crc = 16'hFFFF;
        for (int i = 0; i < len; i++) crc = crc16_step(crc, rep[i]);
        rep[len] = crc[7:0];
        rep[len + 1] = crc[15:8];
        len += 2;
        for (int i = 0; i < len; i++) begin
            rb.data = rep[i];
            rb.last = (i == len - 1);
            rb.coils = coil_state;
            rb.status = status;
            reply_fifo.push_back(rb);
        end
    endtask

    // Advance the shadow line state by one accepted transaction.
    task automatic track_item(input t_in_item it);
        if (!it.kind) begin
            if (line_phase == LINE_IDLE) begin
                reset_frame();
                line_phase = LINE_RECEIVING;
            end
            if (line_phase == LINE_RECEIVING) begin
                if (frame_len < MAX_FRAME_BYTES) begin
                    if (frame_len < 8) head_bytes[frame_len] = it.rx_byte;
                    frame_crc = crc16_step(frame_crc, it.rx_byte);
                    frame_len = frame_len + 1;
                end else begin
                    // Overlong frame: drop it and wait for the bus to go quiet.
                    reset_frame();
                    line_phase = LINE_WAIT_SILENCE;
                end
            end
            silence_cnt = '0;
            return;
        end
        if (line_phase == LINE_IDLE) return;
        if (silence_cnt != 16'hFFFF) silence_cnt = silence_cnt + 1;
        if (line_phase == LINE_RECEIVING) begin
            if (silence_cnt >= short_gap) begin
                decode_frame(it.pins);
                line_phase = LINE_WAIT_SILENCE;
                silence_cnt = '0;
                reset_frame();
            end
        end else if (silence_cnt >= long_gap) begin
            line_phase = LINE_IDLE;
            silence_cnt = '0;
            reset_frame();
        end
    endtask

    // Input driver: presents queued items, with random idle bursts.
    int send_hold = 0;
    always @(posedge i_clk) begin
        t_in_item it;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                track_item(t_in_item'({s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]}));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_hold > 0) begin
                    send_hold--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    s_axis_tdata <= {it.pins, it.rx_byte};
                    s_axis_tuser <= it.kind;
                    s_axis_tvalid <= 1'b1;
                    if (idling_on && $urandom_range(0, 5) == 0) send_hold = $urandom_range(1, 7);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: random stalls on ready, compares each transaction in order.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_reply_byte want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (reply_fifo.size() == 0) begin
                    $display("%0t: unexpected reply byte %h", $time, m_axis_tdata);
                    error_count++;
                end else begin
                    want = reply_fifo.pop_front();
                    if (m_axis_tdata[7:0] !== want.data) begin
                        $display("%0t: tx_byte expected %h actual %h",
                                 $time, want.data, m_axis_tdata[7:0]);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $display("%0t: tx_last expected %b actual %b",
                                 $time, want.last, m_axis_tlast);
                        error_count++;
                    end
                    if (m_axis_tdata[15:8] !== want.coils) begin
                        $display("%0t: coil_bits expected %h actual %h",
                                 $time, want.coils, m_axis_tdata[15:8]);
                        error_count++;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $display("%0t: reply_status expected %0d actual %0d",
                                 $time, want.status, m_axis_tuser);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        pending_items.push_back(t_in_item'({1'b0, b, 8'($urandom)}));
    endtask

    task automatic push_ticks(input int n);
        repeat (n) pending_items.push_back(t_in_item'({1'b1, 8'($urandom), 8'($urandom)}));
    endtask

    // Silence, the frame body with its CRC, then the closing gap.
    task automatic send_frame(input logic [7:0] body [$], input bit bad_crc);
        logic [15:0] crc;
        crc = 16'hFFFF;
        push_ticks((long_gap == 0) ? 1 : long_gap);
        foreach (body[i]) begin
            push_byte(body[i]);
            crc = crc16_step(crc, body[i]);
        end
        if (bad_crc) crc = crc ^ (16'h1 << $urandom_range(0, 15));
        push_byte(crc[7:0]);
        push_byte(crc[15:8]);
        push_ticks(((short_gap == 0) ? 1 : short_gap) + $urandom_range(0, 2));
    endtask

    task automatic send_request(input logic [7:0] sa, input logic [7:0] fc,
                                input logic [15:0] start, input logic [15:0] qty,
                                input logic [7:0] cnt, input logic [7:0] val,
                                input bit bad_crc);
        logic [7:0] body [$];
        body = '{sa, fc, start[15:8], start[7:0], qty[15:8], qty[7:0]};
        if (fc == mrs_pkg::FC_WRITE_MANY) begin
            body.push_back(cnt);
            body.push_back(val);
        end
        send_frame(body, bad_crc);
    endtask

    // Mostly well-formed requests with random content; some noise and broken frames.
    task automatic random_request();
        logic [7:0]  sa, fc, cnt, val;
        logic [15:0] start, qty;
        logic [7:0]  body [$];
        int          pick;
        sa = ($urandom_range(0, 9) == 0) ? 8'($urandom) : own_addr;
        pick = $urandom_range(0, 9);
        fc = (pick < 3) ? mrs_pkg::FC_READ_COILS : (pick < 5) ? mrs_pkg::FC_READ_INPUTS :
             (pick < 7) ? mrs_pkg::FC_WRITE_ONE : (pick < 9) ? mrs_pkg::FC_WRITE_MANY :
             8'($urandom);
        start = $urandom_range(0, 9);
        qty = $urandom_range(0, 9);
        if ($urandom_range(0, 19) == 0) start = 16'($urandom);
        if ($urandom_range(0, 19) == 0) qty = 16'($urandom);
        if (fc == mrs_pkg::FC_WRITE_ONE && $urandom_range(0, 7) != 0)
            qty = $urandom_range(0, 1) ? 16'hFF00 : 16'h0000;
        cnt = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'((qty + 7) / 8);
        val = 8'($urandom);
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            // Truncated frame: short header fields and the four-byte limit.
            repeat ($urandom_range(1, 6)) body.push_back(8'($urandom));
            body[0] = own_addr;
            send_frame(body, 1'b0);
        end else if (pick == 1) begin
            // Bytes during the silence wait keep restarting it.
            repeat ($urandom_range(1, 4)) begin
                push_byte(8'($urandom));
                push_ticks($urandom_range(0, 3));
            end
        end else begin
            send_request(sa, fc, start, qty, cnt, val, $urandom_range(0, 11) == 0);
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || reply_fifo.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mrs_pkg::CFG_ADDR:  own_addr = val[7:0];
            mrs_pkg::CFG_SHORT: short_gap = val;
            mrs_pkg::CFG_LONG:  long_gap = val;
            mrs_pkg::CFG_COILS: coil_num = val[3:0];
            mrs_pkg::CFG_INPS:  input_num = val[3:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] sa, input logic [15:0] sg,
                             input logic [15:0] lg, input logic [3:0] nc,
                             input logic [3:0] ni);
        wait_drained();
        write_reg(mrs_pkg::CFG_ADDR, {8'h00, sa});
        write_reg(mrs_pkg::CFG_SHORT, sg);
        write_reg(mrs_pkg::CFG_LONG, lg);
        write_reg(mrs_pkg::CFG_COILS, {12'h000, nc});
        write_reg(mrs_pkg::CFG_INPS, {12'h000, ni});
    endtask

    task automatic random_phase(input int n_items);
        int goal;
        goal = pending_items.size() + n_items;
        while (pending_items.size() < goal) random_request();
    endtask

    initial begin
        logic [7:0] body [$];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with short gaps: each function, each exception and the odd frames.
        configure(8'd1, 16'd1, 16'd2, 4'd8, 4'd8);
        send_request(8'd1, mrs_pkg::FC_WRITE_MANY, 16'd0, 16'd8, 8'd1, 8'hA5, 1'b0);
        send_request(8'd1, mrs_pkg::FC_READ_COILS, 16'd0, 16'd8, 8'd0, 8'd0, 1'b0);
        send_request(8'd1, mrs_pkg::FC_READ_INPUTS, 16'd0, 16'd8, 8'd0, 8'd0, 1'b0);
        send_request(8'd1, mrs_pkg::FC_WRITE_ONE, 16'd7, 16'h0000, 8'd0, 8'd0, 1'b0);
        send_request(8'd1, mrs_pkg::FC_WRITE_ONE, 16'd1, 16'hFF00, 8'd0, 8'd0, 1'b0);
        send_request(8'd1, 8'hFF, 16'd0, 16'd1, 8'd0, 8'd0, 1'b0);
        send_request(8'd1, mrs_pkg::FC_READ_COILS, 16'hFFFF, 16'd1, 8'd0, 8'd0, 1'b0);
        send_request(8'd1, mrs_pkg::FC_READ_COILS, 16'd7, 16'd2, 8'd0, 8'd0, 1'b0);
        send_request(8'd1, mrs_pkg::FC_READ_COILS, 16'd0, 16'd1, 8'd0, 8'd0, 1'b1);
        send_request(8'd9, mrs_pkg::FC_READ_COILS, 16'd0, 16'd1, 8'd0, 8'd0, 1'b0);
        body = '{8'd1, mrs_pkg::FC_READ_COILS};
        send_frame(body, 1'b0);
        // Overlong frame gets dropped after the frame size limit.
        push_ticks(2);
        repeat (MAX_FRAME_BYTES + 1) push_byte(8'($urandom));
        push_ticks(3);
        // Ticks while the bus is idle are ignored.
        push_ticks(5);

        // Random part across several register settings, extremes included.
        configure(8'd247, 16'd3, 16'd5, 4'd1, 4'd2);
        random_phase(8);
        configure(8'd0, 16'd0, 16'd0, 4'd0, 4'd12);
        random_phase(6);
        configure(8'd255, 16'd2, 16'd1, 4'd15, 4'd8);
        random_phase(8);
        // Huge gaps: no silence here is long enough to close a frame or idle the bus.
        configure(8'd1, 16'hFFFF, 16'hFFFF, 4'd8, 4'd1);
        repeat (3) begin
            push_byte(8'($urandom));
            push_ticks($urandom_range(0, 3));
        end
        configure(8'h5A, 16'd2, 16'd3, 4'd5, 4'd7);
        random_phase(8);
        wait_drained();
        idling_on = 1'b0;
        configure(8'd17, 16'd1, 16'd1, 4'd8, 4'd8);
        random_phase(12);

        wait_drained();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
